### rtl/combinatorial_set_rank_unrank_assert.svh
// ----------------------------------------------------------------------------
// combinatorial_set_rank_unrank_assert.svh
// Assertion macros shared by the rank / unrank block. Clock is clk and the
// active-low synchronous reset rst_n masks every check.
// ----------------------------------------------------------------------------
`ifndef COMBINATORIAL_SET_RANK_UNRANK_ASSERT_SVH
`define COMBINATORIAL_SET_RANK_UNRANK_ASSERT_SVH

// Same-cycle implication
`define CSRU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("csru assertion failed");

// Next-cycle implication
`define CSRU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("csru assertion failed");

`endif

### rtl/csru_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csru_pkg
// Types, codes and the binomial table of the combinatorial set rank/unrank
// block.
// ----------------------------------------------------------------------------
package csru_pkg;

  localparam int SET_LANES = 5;   // square fields in one transaction
  localparam int TAB_ROWS  = 65;  // binomial rows, n = 0..64
  localparam int RANK_W    = 23;
  localparam int SQ_W      = 6;

  // Request codes
  localparam logic REQ_RANK   = 1'b0;
  localparam logic REQ_UNRANK = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [2:0]        set_count;
    logic [SQ_W-1:0]   square_a;
    logic [SQ_W-1:0]   square_b;
    logic [SQ_W-1:0]   square_c;
    logic [SQ_W-1:0]   square_d;
    logic [SQ_W-1:0]   square_e;
    logic [RANK_W-1:0] rank_in;
  } csru_req_t;

  typedef struct packed {
    logic [RANK_W-1:0] rank_out;
    logic [SQ_W-1:0]   sorted_a;
    logic [SQ_W-1:0]   sorted_b;
    logic [SQ_W-1:0]   sorted_c;
    logic [SQ_W-1:0]   sorted_d;
    logic [SQ_W-1:0]   sorted_e;
    logic              range_error;
  } csru_res_t;

  // Control of the shared add/subtract unit
  typedef struct packed {
    logic       op_sub;  // 1: acc - binom, 0: acc + binom
    logic [6:0] n;       // table row
    logic [2:0] k;       // table column, binomial(n, k+1)
  } csru_arith_ctl_t;

  typedef logic [SET_LANES-1:0][RANK_W-1:0] binom_row_t;
  typedef binom_row_t [TAB_ROWS-1:0]        binom_tab_t;

  // Pascal's triangle, built at elaboration: entry [n][k] = binomial(n, k+1)
  function automatic binom_tab_t build_binom();
    binom_tab_t t;
    t = '0;
    for (int n = 1; n < TAB_ROWS; n++) begin
      for (int k = 0; k < SET_LANES; k++) begin
        t[n][k] = ((k == 0) ? RANK_W'(1) : t[n-1][k-1]) + t[n-1][k];
      end
    end
    return t;
  endfunction

  localparam binom_tab_t BINOM_TAB = build_binom();

endpackage

### rtl/combinatorial_set_rank_unrank.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// combinatorial_set_rank_unrank
// Ranks and unranks sets of one to five board squares in the combinatorial
// number system, using one shared binomial add/subtract unit.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken at a rising edge with start high and busy low.
//   in_data carries the request: rank (sort the squares, sum the binomials)
//   or unrank (rebuild ascending squares from an index).
//   busy stays high from the edge after the transaction until the result
//   has been registered. The result shows on out_data for exactly one cycle
//   with out_valid high; the receiver cannot stall it.
// Steps, one shared-unit pass per cycle:
//   rank:   5 odd-even sort passes, one accumulate step per square, done.
//   unrank: range check, then per position one step per square increment,
//           one final compare and one subtract, then done; out of range,
//           the range check goes straight to done.
// Back-to-back: busy is low in the strobe cycle, so the next start is taken
//   at the edge ending it.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops
// out_valid; no result is pending afterward.
// ----------------------------------------------------------------------------
`include "combinatorial_set_rank_unrank_assert.svh"

module combinatorial_set_rank_unrank
  import csru_pkg::*;
#(
  parameter int MAX_SET       = 5,
  parameter int BOARD_SQUARES = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  csru_req_t in_data,
  output logic      out_valid,
  output csru_res_t out_data
);

  localparam logic [2:0] MAX_CNT = 3'(MAX_SET);
  localparam logic [6:0] BOARD_N = 7'(BOARD_SQUARES);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SORT  = 7'b0000010,
    ST_RANK  = 7'b0000100,
    ST_CHECK = 7'b0001000,
    ST_STEP  = 7'b0010000,
    ST_SUB   = 7'b0100000,
    ST_DONE  = 7'b1000000
  } csru_state_t;

  csru_state_t       state_r, state_nxt;
  logic              type_r, type_nxt;
  logic [2:0]        count_r, count_nxt;
  logic [2:0]        idx_r, idx_nxt;
  logic [2:0]        pass_r, pass_nxt;
  logic [SQ_W-1:0]   s_r, s_nxt;
  logic [RANK_W-1:0] acc_r, acc_nxt;
  logic              err_r, err_nxt;
  logic [6:0]        sq_r   [SET_LANES];
  logic [6:0]        sq_nxt [SET_LANES];
  logic              out_valid_r, out_valid_nxt;
  csru_res_t         out_data_r, out_data_nxt;

  csru_arith_ctl_t   ctl;
  logic [RANK_W-1:0] arith_res;
  logic              arith_borrow;
  logic [2:0]        cnt_in;
  logic [6:0]        s_inc;
  logic [SQ_W-1:0]   lane_sq [SET_LANES];

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign s_inc = {1'b0, s_r} + 7'd1;

  // count saturation
  always_comb begin
    if (in_data.set_count == 3'd0) begin
      cnt_in = 3'd1;
    end else if (in_data.set_count > MAX_CNT) begin
      cnt_in = MAX_CNT;
    end else begin
      cnt_in = in_data.set_count;
    end
  end

  assign lane_sq[0] = in_data.square_a;
  assign lane_sq[1] = in_data.square_b;
  assign lane_sq[2] = in_data.square_c;
  assign lane_sq[3] = in_data.square_d;
  assign lane_sq[4] = in_data.square_e;

  // operand select for the shared unit
  always_comb begin
    ctl = '0;
    case (state_r)
      ST_RANK: begin
        ctl.op_sub = 1'b0;
        ctl.n      = sq_r[idx_r];
        ctl.k      = idx_r;
      end
      ST_CHECK: begin
        ctl.op_sub = 1'b1;
        ctl.n      = BOARD_N;
        ctl.k      = count_r - 3'd1;
      end
      ST_STEP: begin
        ctl.op_sub = 1'b1;
        ctl.n      = s_inc;
        ctl.k      = idx_r;
      end
      ST_SUB: begin
        ctl.op_sub = 1'b1;
        ctl.n      = {1'b0, s_r};
        ctl.k      = idx_r;
      end
      default: ctl = '0;
    endcase
  end

  csru_arith u_arith (
    .acc    (acc_r),
    .ctl    (ctl),
    .res    (arith_res),
    .borrow (arith_borrow)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    type_nxt      = type_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    pass_nxt      = pass_r;
    s_nxt         = s_r;
    acc_nxt       = acc_r;
    err_nxt       = err_r;
    sq_nxt        = sq_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          type_nxt  = in_data.req_type;
          count_nxt = cnt_in;
          err_nxt   = 1'b0;
          pass_nxt  = 3'd0;
          idx_nxt   = 3'd0;
          if (in_data.req_type == REQ_RANK) begin
            acc_nxt = '0;
            // unused lanes get a sentinel above every square
            for (int p = 0; p < SET_LANES; p++) begin
              sq_nxt[p] = (3'(p) < cnt_in) ? {1'b0, lane_sq[p]} : 7'd64;
            end
            state_nxt = ST_SORT;
          end else begin
            acc_nxt = in_data.rank_in;
            for (int p = 0; p < SET_LANES; p++) begin
              sq_nxt[p] = '0;
            end
            state_nxt = ST_CHECK;
          end
        end
      end

      // odd-even transposition, disjoint pairs per pass
      ST_SORT: begin
        for (int p = 0; p < SET_LANES - 1; p++) begin
          if ((1'(p) == pass_r[0]) && (sq_r[p+1] < sq_r[p])) begin
            sq_nxt[p]   = sq_r[p+1];
            sq_nxt[p+1] = sq_r[p];
          end
        end
        pass_nxt = pass_r + 3'd1;
        if (pass_r == 3'(SET_LANES - 1)) begin
          state_nxt = ST_RANK;
        end
      end

      // accumulate binomial(sq[i], i+1)
      ST_RANK: begin
        acc_nxt = arith_res;
        idx_nxt = idx_r + 3'd1;
        if (idx_r == count_r - 3'd1) begin
          state_nxt = ST_DONE;
        end
      end

      // index must be below binomial(board, count)
      ST_CHECK: begin
        if (!arith_borrow) begin
          err_nxt   = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          idx_nxt   = count_r - 3'd1;
          s_nxt     = SQ_W'(count_r - 3'd1);
          state_nxt = ST_STEP;
        end
      end

      // advance the square while the next binomial still fits
      ST_STEP: begin
        if ((s_inc < BOARD_N) && !arith_borrow) begin
          s_nxt = s_inc[SQ_W-1:0];
        end else begin
          state_nxt = ST_SUB;
        end
      end

      // take the binomial off and move to the next lower position
      ST_SUB: begin
        acc_nxt         = arith_res;
        sq_nxt[idx_r]   = {1'b0, s_r};
        if (idx_r == 3'd0) begin
          state_nxt = ST_DONE;
        end else begin
          idx_nxt   = idx_r - 3'd1;
          s_nxt     = SQ_W'(idx_r - 3'd1);
          state_nxt = ST_STEP;
        end
      end

      // register the result for its one-cycle strobe
      ST_DONE: begin
        out_valid_nxt            = 1'b1;
        out_data_nxt.rank_out    = (type_r == REQ_RANK) ? acc_r : '0;
        out_data_nxt.range_error = err_r;
        out_data_nxt.sorted_a    = (!err_r && count_r > 3'd0) ? sq_r[0][SQ_W-1:0] : '0;
        out_data_nxt.sorted_b    = (!err_r && count_r > 3'd1) ? sq_r[1][SQ_W-1:0] : '0;
        out_data_nxt.sorted_c    = (!err_r && count_r > 3'd2) ? sq_r[2][SQ_W-1:0] : '0;
        out_data_nxt.sorted_d    = (!err_r && count_r > 3'd3) ? sq_r[3][SQ_W-1:0] : '0;
        out_data_nxt.sorted_e    = (!err_r && count_r > 3'd4) ? sq_r[4][SQ_W-1:0] : '0;
        state_nxt                = ST_IDLE;
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    type_r     <= type_nxt;
    count_r    <= count_nxt;
    idx_r      <= idx_nxt;
    pass_r     <= pass_nxt;
    s_r        <= s_nxt;
    acc_r      <= acc_nxt;
    err_r      <= err_nxt;
    sq_r       <= sq_nxt;
    out_data_r <= out_data_nxt;
  end

  // checks
  `CSRU_ASSERT_NEXT(a_busy_after_start, start && !busy, busy)
  `CSRU_ASSERT_NEXT(a_strobe_after_done, state_r == ST_DONE, out_valid && !busy)
  `CSRU_ASSERT_NOW(a_err_zero_result, out_valid && out_data.range_error, out_data.rank_out == '0 && out_data.sorted_a == '0)
  `CSRU_ASSERT_NOW(a_idx_in_set, state_r == ST_STEP || state_r == ST_SUB, idx_r < count_r && {3'b000, idx_r} <= s_r)

endmodule

### rtl/csru_arith.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csru_arith
// Shared arithmetic unit: looks up one binomial and adds it to or subtracts
// it from the accumulator. Borrow doubles as the compare result.
// ----------------------------------------------------------------------------
module csru_arith
  import csru_pkg::*;
(
  input  logic [RANK_W-1:0] acc,
  input  csru_arith_ctl_t   ctl,
  output logic [RANK_W-1:0] res,
  output logic              borrow
);

  logic [RANK_W-1:0] operand;
  logic [RANK_W:0]   sum;

  // table read, one place
  assign operand = BINOM_TAB[ctl.n][ctl.k];

  // one wide add or subtract
  always_comb begin
    if (ctl.op_sub) begin
      sum = {1'b0, acc} - {1'b0, operand};
    end else begin
      sum = {1'b0, acc} + {1'b0, operand};
    end
  end

  assign res    = sum[RANK_W-1:0];
  assign borrow = ctl.op_sub & sum[RANK_W];

endmodule
